// ----- hw/rtl/bfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame allocator package
// Field widths, operation and status codes, and defaults shared by the
// bitmap frame allocator and its submodules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

    localparam int OP_W     = 2;
    localparam int START_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;
    localparam int FRAME_W  = 12;
    localparam int TOTAL_W  = 13;

    localparam int FRAMES_DEF    = 4096;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd4096;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RESERVE = 2'd2,
        OP_REINIT  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_RUN     = 2'd1,
        STAT_ZERO_COUNT = 2'd2
    } t_status;

    // Selects what the shared word unit computes in a given cycle.
    typedef enum logic {
        UNIT_SCAN,
        UNIT_MARK
    } t_unit_mode;

endpackage

`default_nettype wire

// ----- hw/rtl/bfa_ifs.sv -----
// ----------------------------------------------------------------------------
// Frame allocator channels
// Valid/ready channels for requests, responses and the total-frames register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bfa_req_if;
    import bfa_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [START_W-1:0] start_frame;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output op, output start_frame, output count, input ready);
    modport sink   (input valid, input op, input start_frame, input count, output ready);
endinterface

interface bfa_rsp_if;
    import bfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
    logic [COUNT_W-1:0]  used_blocks;
    logic [COUNT_W-1:0]  free_blocks;

    modport source (output valid, output status, output frame, output used_blocks,
                    output free_blocks, input ready);
    modport sink   (input valid, input status, input frame, input used_blocks,
                    input free_blocks, output ready);
endinterface

interface bfa_cfg_if;
    import bfa_pkg::*;

    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/bfa_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                        i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- hw/rtl/bfa_word_unit.sv -----
// ----------------------------------------------------------------------------
// Frame allocator word unit
// Shared per-word logic: first-fit run detection while scanning, and masked
// set or clear of a bit range while marking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bfa_word_unit #(
    parameter int WORD_BITS = bfa_pkg::WORD_BITS_DEF
) (
    input  wire logic [WORD_BITS-1:0]          i_word,
    input  wire bfa_pkg::t_unit_mode           i_mode,
    input  wire logic                          i_set,
    input  wire logic [bfa_pkg::COUNT_W-1:0]   i_need,
    input  wire logic [bfa_pkg::COUNT_W-1:0]   i_carry,
    input  wire logic [$clog2(WORD_BITS):0]    i_lo,
    input  wire logic [$clog2(WORD_BITS):0]    i_hi,
    output logic                               o_hit,
    output logic [$clog2(WORD_BITS)-1:0]       o_pos,
    output logic [bfa_pkg::COUNT_W-1:0]        o_carry,
    output logic [WORD_BITS-1:0]               o_word
);
    import bfa_pkg::*;

    localparam int LOGW = $clog2(WORD_BITS);
    localparam int LW   = LOGW + 1;

    logic [WORD_BITS-1:0] ones;
    logic [WORD_BITS-1:0] free_v;
    logic [WORD_BITS-1:0] pre_used;
    logic [WORD_BITS-1:0] runs;
    logic [WORD_BITS-1:0] pw;
    logic [WORD_BITS-1:0] thr;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] cand;
    logic [LW-1:0]        acc;
    logic [LW-1:0]        need_s;
    logic [COUNT_W-1:0]   gap;
    logic [COUNT_W:0]     csum;
    logic [LOGW-1:0]      top_used;
    logic [LOGW-1:0]      pos;

    always_comb begin
        ones   = '1;
        free_v = ~i_word;

        // A bit of pre_used is set when some frame at or below it is used.
        pre_used = i_word;
        for (int s = 1; s < WORD_BITS; s = s * 2) begin
            pre_used = pre_used | (pre_used << s);
        end

        // Runs of i_need free frames lying wholly in this word, by doubling.
        runs   = '0;
        need_s = i_need[LW-1:0];
        acc    = '0;
        pw     = free_v;
        if (i_need <= COUNT_W'(WORD_BITS)) begin
            runs = ones;
            for (int b = 0; b < LW; b++) begin
                if (need_s[b]) begin
                    runs = runs & (pw << acc);
                    acc  = acc + LW'(1 << b);
                end
                pw = pw & (pw << (1 << b));
            end
        end

        // Runs that continue the free tail carried in from earlier words.
        gap = '0;
        if (i_carry >= i_need) begin
            thr = ones;
        end else begin
            gap = i_need - i_carry - COUNT_W'(1);
            if (gap >= COUNT_W'(WORD_BITS)) begin
                thr = '0;
            end else begin
                thr = ones << gap[LOGW-1:0];
            end
        end

        hi_mask = ~(ones << i_hi);
        lo_mask = ones << i_lo;
        cand    = (runs | (~pre_used & thr)) & hi_mask;

        pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (cand[j]) begin
                pos = LOGW'(j);
            end
        end

        top_used = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (i_word[j]) begin
                top_used = LOGW'(j);
            end
        end

        csum = {1'b0, i_carry} + (COUNT_W + 1)'(WORD_BITS);
        if (i_word == '0) begin
            o_carry = csum[COUNT_W] ? '1 : csum[COUNT_W-1:0];
        end else begin
            o_carry = COUNT_W'(WORD_BITS - 1) - COUNT_W'(top_used);
        end

        o_hit = (i_mode == UNIT_SCAN) && (cand != '0);
        o_pos = pos;

        if (i_mode == UNIT_MARK) begin
            o_word = i_set ? (i_word | (lo_mask & hi_mask)) : (i_word & ~(lo_mask & hi_mask));
        end else begin
            o_word = i_word;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bitmap_frame_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit allocator over a one-bit-per-frame usage map held in a RAM of
// WORD_BITS-bit words, with a used-frame count. It allocates a run of frames,
// frees or reserves a range, or marks every frame used, and answers each
// request with one response word carrying the status, the allocated start
// frame and the used and free counts. One request is handled at a time; the
// request channel is ready only while the block is idle. Allocation scans the
// map at one word per cycle and then read-modify-writes the words of the run,
// reading each in ST_MARK_RD and writing it back in ST_MARK_WR. Free and
// reserve read-modify-write the words of their range in the same way, and
// reinitialisation rewrites every word with ones. Marking goes through the
// single RAM port pair and the shared word unit. After reset the map is
// filled with ones in a clearing pass over every word before the first
// request is taken; the register write channel is always ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bitmap_frame_allocator #(
    parameter int FRAMES    = bfa_pkg::FRAMES_DEF,
    parameter int WORD_BITS = bfa_pkg::WORD_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bfa_cfg_if.sink   i_cfg,
    bfa_req_if.sink   i_req,
    bfa_rsp_if.source o_rsp
);
    import bfa_pkg::*;

    localparam int LOGW      = $clog2(WORD_BITS);
    localparam int LW        = LOGW + 1;
    localparam int MAP_WORDS = (FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = ADDR_W + LOGW;
    localparam int AW        = ((IDX_W > COUNT_W) ? IDX_W : COUNT_W) + 1;
    localparam logic [ADDR_W-1:0]  LAST_WORD  = ADDR_W'(MAP_WORDS - 1);
    localparam logic [COUNT_W-1:0] USED_RESET =
        (FRAMES < int'(TOTAL_RESET)) ? COUNT_W'(FRAMES) : TOTAL_RESET;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN_FIRST,
        ST_SCAN,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_DONE
    } t_state;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [COUNT_W-1:0]  r_n, n_n;
    logic [AW-1:0]       r_s, n_s;
    logic [AW-1:0]       r_e, n_e;
    logic [ADDR_W-1:0]   r_w, n_w;
    logic [COUNT_W-1:0]  r_carry, n_carry;
    t_status             r_status, n_status;
    logic [FRAME_W-1:0]  r_frame, n_frame;
    logic [COUNT_W-1:0]  r_used, n_used;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic                r_clear_op, n_clear_op;
    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [FRAME_W-1:0]  r_out_frame, n_out_frame;
    logic [COUNT_W-1:0]  r_out_used, n_out_used;
    logic [COUNT_W-1:0]  r_out_free, n_out_free;

    logic [COUNT_W-1:0]  eff_total;
    logic [COUNT_W-1:0]  free_now;
    logic [AW-1:0]       base;
    logic [AW-1:0]       next_base;
    logic [AW-1:0]       lim;
    logic [AW-1:0]       span;
    logic [AW-1:0]       lo_diff;
    logic [AW-1:0]       req_s;
    logic [AW-1:0]       req_end;
    logic [AW-1:0]       req_e;
    logic [AW-1:0]       found;
    logic [AW-1:0]       range_len;
    logic [COUNT_W-1:0]  k_len;
    logic [COUNT_W:0]    used_sum;
    logic [COUNT_W-1:0]  used_after;
    logic [LW-1:0]       unit_lo;
    logic [LW-1:0]       unit_hi;
    t_unit_mode          unit_mode;
    logic                unit_hit;
    logic [LOGW-1:0]     unit_pos;
    logic [COUNT_W-1:0]  unit_carry;
    logic [WORD_BITS-1:0] unit_word;
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [WORD_BITS-1:0] ram_wr_data;
    logic [WORD_BITS-1:0] ram_rd_data;

    // ------------------------------------------------------------------
    // Datapath around the map
    // ------------------------------------------------------------------
    always_comb begin
        eff_total = (AW'(r_total) < AW'(FRAMES)) ? r_total : COUNT_W'(FRAMES);
        free_now  = (r_used < eff_total) ? (eff_total - r_used) : '0;

        base      = AW'({r_w, {LOGW{1'b0}}});
        next_base = base + AW'(WORD_BITS);

        lim     = (r_state == ST_SCAN) ? AW'(eff_total) : r_e;
        span    = lim - base;
        unit_hi = (span >= AW'(WORD_BITS)) ? LW'(WORD_BITS) : span[LW-1:0];
        lo_diff = r_s - base;
        unit_lo = (r_s > base) ? lo_diff[LW-1:0] : '0;

        req_s   = AW'(i_req.start_frame);
        req_end = req_s + AW'(i_req.count);
        req_e   = (req_end < AW'(eff_total)) ? req_end : AW'(eff_total);

        found = base + AW'(unit_pos) + AW'(1) - AW'(r_n);

        // The used count moves once for the whole range, saturating at both ends.
        range_len = r_e - r_s;
        k_len     = range_len[COUNT_W-1:0];
        used_sum  = {1'b0, r_used} + {1'b0, k_len};
        if (r_op == OP_FREE) begin
            used_after = (r_used < k_len) ? '0 : (r_used - k_len);
        end else if (r_used >= eff_total) begin
            used_after = r_used;
        end else if ((eff_total - r_used) < k_len) begin
            used_after = eff_total;
        end else begin
            used_after = used_sum[COUNT_W-1:0];
        end

        unit_mode   = (r_state == ST_SCAN) ? UNIT_SCAN : UNIT_MARK;
        ram_rd_addr = (r_state == ST_SCAN) ? (r_w + ADDR_W'(1)) : r_w;
        ram_wr_en   = (r_state == ST_CLEAR) || (r_state == ST_MARK_WR);
        ram_wr_data = (r_state == ST_CLEAR) ? '1 : unit_word;
    end

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_w),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    bfa_word_unit #(
        .WORD_BITS (WORD_BITS)
    ) u_word (
        .i_word  (ram_rd_data),
        .i_mode  (unit_mode),
        .i_set   (r_op != OP_FREE),
        .i_need  (r_n),
        .i_carry (r_carry),
        .i_lo    (unit_lo),
        .i_hi    (unit_hi),
        .o_hit   (unit_hit),
        .o_pos   (unit_pos),
        .o_carry (unit_carry),
        .o_word  (unit_word)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_n          = r_n;
        n_s          = r_s;
        n_e          = r_e;
        n_w          = r_w;
        n_carry      = r_carry;
        n_status     = r_status;
        n_frame      = r_frame;
        n_used       = r_used;
        n_total      = (i_cfg.valid) ? i_cfg.data : r_total;
        n_clear_op   = r_clear_op;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_frame  = r_out_frame;
        n_out_used   = r_out_used;
        n_out_free   = r_out_free;

        case (r_state)
            ST_CLEAR: begin
                if (r_w == LAST_WORD) begin
                    n_w        = '0;
                    n_clear_op = 1'b0;
                    n_state    = r_clear_op ? ST_DONE : ST_IDLE;
                end else begin
                    n_w = r_w + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_op     = t_op'(i_req.op);
                    n_n      = i_req.count;
                    n_status = STAT_OK;
                    n_frame  = '0;
                    case (t_op'(i_req.op))
                        OP_ALLOC: begin
                            if (i_req.count == '0) begin
                                n_status = STAT_ZERO_COUNT;
                                n_state  = ST_DONE;
                            end else if (free_now < i_req.count) begin
                                n_status = STAT_NO_RUN;
                                n_state  = ST_DONE;
                            end else begin
                                n_w     = '0;
                                n_carry = '0;
                                n_state = ST_SCAN_FIRST;
                            end
                        end
                        OP_FREE, OP_RESERVE: begin
                            n_s = req_s;
                            n_e = req_e;
                            if (req_e > req_s) begin
                                n_w     = req_s[LOGW +: ADDR_W];
                                n_state = ST_MARK_RD;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        OP_REINIT: begin
                            n_used     = eff_total;
                            n_w        = '0;
                            n_clear_op = 1'b1;
                            n_state    = ST_CLEAR;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SCAN_FIRST: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (unit_hit) begin
                    // The run may start in an earlier word, so marking restarts there.
                    n_s     = found;
                    n_e     = found + AW'(r_n);
                    n_frame = found[FRAME_W-1:0];
                    n_w     = found[LOGW +: ADDR_W];
                    n_state = ST_MARK_RD;
                end else if (next_base >= AW'(eff_total)) begin
                    n_status = STAT_NO_RUN;
                    n_state  = ST_DONE;
                end else begin
                    n_w     = r_w + ADDR_W'(1);
                    n_carry = unit_carry;
                end
            end
            ST_MARK_RD: begin
                n_state = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                if (next_base >= r_e) begin
                    n_used  = used_after;
                    n_state = ST_DONE;
                end else begin
                    n_w     = r_w + ADDR_W'(1);
                    n_state = ST_MARK_RD;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_frame  = r_frame;
                    n_out_used   = r_used;
                    n_out_free   = free_now;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_w         <= '0;
            r_used      <= USED_RESET;
            r_total     <= TOTAL_RESET;
            r_clear_op  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_w         <= n_w;
            r_used      <= n_used;
            r_total     <= n_total;
            r_clear_op  <= n_clear_op;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_n          <= n_n;
        r_s          <= n_s;
        r_e          <= n_e;
        r_carry      <= n_carry;
        r_status     <= n_status;
        r_frame      <= n_frame;
        r_out_status <= n_out_status;
        r_out_frame  <= n_out_frame;
        r_out_used   <= n_out_used;
        r_out_free   <= n_out_free;
    end

    assign i_cfg.ready       = 1'b1;
    assign i_req.ready       = (r_state == ST_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.frame       = r_out_frame;
    assign o_rsp.used_blocks = r_out_used;
    assign o_rsp.free_blocks = r_out_free;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A carried free tail as long as the request would already have been a hit.
    a_carry_below_need: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_carry < r_n))
        else $error("scan carried a free run at least as long as the request");

    // Every word written back while marking overlaps the range being marked.
    a_mark_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MARK_WR) |-> ((base < r_e) && (next_base > r_s)))
        else $error("marking touched a word outside the range");

    // A failed or empty request never reports a start frame.
    a_frame_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != STAT_OK)) |-> (r_out_frame == '0))
        else $error("non-zero frame with a failing status");

    // A response word only appears when the sequencer hands one over.
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("response raised outside the completion state");

endmodule

`default_nettype wire
